@@ rtl/core/hidu_pkg.sv @@
// hidu_pkg: shared constants, register codes, reset values and link structs
// for the heartbeat interval detector unit
// no dependencies
package hidu_pkg;

    // field widths
    localparam int SAMPLE_W   = 10;
    localparam int LEVEL_W    = 10;
    localparam int INTERVAL_W = 12;
    localparam int RATE_W     = 8;
    localparam int PERIOD_W   = 4;
    localparam int TIMEOUT_W  = 16;
    localparam int BLANK_W    = 12;

    // elapsed time is kept modulo 2^32 and walked one digit per cycle
    localparam int ELAP_W    = 32;
    localparam int DIGIT_W   = 4;
    localparam int NDIG      = ELAP_W / DIGIT_W;
    localparam int DCNT_W    = $clog2(NDIG);
    localparam int LO_DIGITS = INTERVAL_W / DIGIT_W;

    // apb port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_PERIOD    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEF_THR   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEF_LEVEL = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BLANKING  = 3'd4;

    // reset values
    localparam logic [PERIOD_W-1:0]   RST_PERIOD    = 4'd2;
    localparam logic [LEVEL_W-1:0]    RST_THRESHOLD = 10'd530;
    localparam logic [LEVEL_W-1:0]    RST_LEVEL     = 10'd512;
    localparam logic [TIMEOUT_W-1:0]  RST_TIMEOUT   = 16'd2500;
    localparam logic [BLANK_W-1:0]    RST_BLANKING  = 12'd250;
    localparam logic [INTERVAL_W-1:0] RST_INTERVAL  = 12'd600;

    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 12'd4095;
    localparam logic [RATE_W-1:0]     RATE_MAX     = 8'd255;

    // history and rate division
    localparam int HIST_DEPTH_DEF = 10;
    localparam int DIV_W          = 16;
    localparam logic [DIV_W-1:0] RATE_NUM = 16'd60000;

    // x/5 as (x * 3277) >> 14, exact for 12-bit x
    localparam int DIV5_MUL   = 3277;
    localparam int DIV5_SHIFT = 14;

    // elapsed unit control and status
    typedef struct packed {
        logic start;
        logic clear;
    } t_elap_ctl;

    typedef struct packed {
        logic busy;
        logic done;
        logic gt_settle;
        logic gt_blank;
        logic gt_timeout;
        logic over_max;
    } t_elap_stat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // settle time (interval/5)*3
    function automatic logic [INTERVAL_W-1:0] settle_of(input logic [INTERVAL_W-1:0] iv);
        logic [2*INTERVAL_W-1:0] prod;
        logic [INTERVAL_W-1:0]   fifth;
        logic [INTERVAL_W+1:0]   triple;
        prod   = {{INTERVAL_W{1'b0}}, iv} * (2*INTERVAL_W)'(DIV5_MUL);
        fifth  = prod[DIV5_SHIFT +: INTERVAL_W];
        triple = {2'b00, fifth} + {1'b0, fifth, 1'b0};
        return triple[INTERVAL_W-1:0];
    endfunction

endpackage

@@ rtl/core/heartbeat_interval_detector_unit.sv @@
// Heartbeat interval detector: takes one 10-bit pulse-sensor sample per request and
// returns one result per sample (rate in beats per minute, last beat interval, pulse
// flag, new-rate flag, threshold). Elapsed time since the last beat is kept as a 32-bit
// value that is advanced and compared one 4-bit digit per cycle; a sample that yields a
// new rate adds a bit-serial division of the history sum over the depth and, unless the
// average is zero, a second division of 60000 over the average. One sample is processed
// at a time; a finished result waits in the output register while the next sample is
// accepted. Configuration is an APB-style port with registers at byte addresses 0 to 16;
// pready is always high.
// depends on hidu_pkg, hidu_elapsed, hidu_div
module heartbeat_interval_detector_unit #(
    parameter int HISTORY_DEPTH = hidu_pkg::HIST_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [hidu_pkg::SAMPLE_W-1:0]     i_sample,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [hidu_pkg::RATE_W-1:0]       o_beats_per_minute,
    output logic [hidu_pkg::INTERVAL_W-1:0]   o_beat_interval_ms,
    output logic                              o_pulse_active,
    output logic                              o_new_rate,
    output logic [hidu_pkg::LEVEL_W-1:0]      o_threshold_level,
    // configuration
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [hidu_pkg::ADDR_W-1:0]       i_paddr,
    input  logic [hidu_pkg::DATA_W-1:0]       i_pwdata,
    output logic [hidu_pkg::DATA_W-1:0]       o_prdata,
    output logic                              o_pready
);

    localparam int IW    = hidu_pkg::INTERVAL_W;
    localparam int LW    = hidu_pkg::LEVEL_W;
    localparam int SUM_W = IW + $clog2(HISTORY_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ELAP   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_AVG    = 3'd3;
    localparam logic [2:0] S_RATE   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    // configuration registers
    logic [hidu_pkg::PERIOD_W-1:0]  r_period;
    logic [LW-1:0]                  r_def_thr;
    logic [LW-1:0]                  r_def_lvl;
    logic [hidu_pkg::TIMEOUT_W-1:0] r_timeout;
    logic [hidu_pkg::BLANK_W-1:0]   r_blank;

    // detector state
    logic [2:0]                     r_state, n_state;
    logic [hidu_pkg::SAMPLE_W-1:0]  r_sample, n_sample;
    logic [IW-1:0]                  r_interval, n_interval;
    logic [IW-1:0]                  r_hist [HISTORY_DEPTH];
    logic [IW-1:0]                  n_hist [HISTORY_DEPTH];
    logic [SUM_W-1:0]               r_sum, n_sum;
    logic [LW-1:0]                  r_thr, n_thr;
    logic [LW-1:0]                  r_peak, n_peak;
    logic [LW-1:0]                  r_trough, n_trough;
    logic                           r_in_pulse, n_in_pulse;
    logic                           r_first, n_first;
    logic                           r_second, n_second;
    logic [hidu_pkg::RATE_W-1:0]    r_rate, n_rate;
    logic                           r_fresh, n_fresh;
    logic [IW-1:0]                  r_avg, n_avg;

    // output register
    logic                           r_out_valid, n_out_valid;
    logic                           out_load;
    logic [hidu_pkg::RATE_W-1:0]    r_o_bpm;
    logic [IW-1:0]                  r_o_interval;
    logic                           r_o_pulse;
    logic                           r_o_fresh;
    logic [LW-1:0]                  r_o_thr;

    // unit links
    hidu_pkg::t_elap_ctl            elap_ctl;
    hidu_pkg::t_elap_stat           elap_stat;
    logic [IW-1:0]                  elap_lo;
    hidu_pkg::t_div_stat            div_stat;
    logic                           div_start;
    logic [hidu_pkg::DIV_W-1:0]     div_dividend;
    logic [hidu_pkg::DIV_W-1:0]     div_divisor;
    logic [hidu_pkg::DIV_W-1:0]     div_quo;

    logic [IW-1:0]                  sat_interval;
    logic                           below_thr;
    logic                           above_thr;
    logic                           beat;
    logic [LW-1:0]                  amp;
    logic [LW-1:0]                  mid;
    logic [hidu_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_wr;

    // apb register file
    assign o_pready = 1'b1;
    assign reg_idx  = i_paddr[hidu_pkg::ADDR_W-1:2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= hidu_pkg::RST_PERIOD;
            r_def_thr <= hidu_pkg::RST_THRESHOLD;
            r_def_lvl <= hidu_pkg::RST_LEVEL;
            r_timeout <= hidu_pkg::RST_TIMEOUT;
            r_blank   <= hidu_pkg::RST_BLANKING;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                hidu_pkg::REG_PERIOD:    r_period  <= i_pwdata[hidu_pkg::PERIOD_W-1:0];
                hidu_pkg::REG_DEF_THR:   r_def_thr <= i_pwdata[LW-1:0];
                hidu_pkg::REG_DEF_LEVEL: r_def_lvl <= i_pwdata[LW-1:0];
                hidu_pkg::REG_TIMEOUT:   r_timeout <= i_pwdata[hidu_pkg::TIMEOUT_W-1:0];
                hidu_pkg::REG_BLANKING:  r_blank   <= i_pwdata[hidu_pkg::BLANK_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            hidu_pkg::REG_PERIOD:    o_prdata = hidu_pkg::DATA_W'(r_period);
            hidu_pkg::REG_DEF_THR:   o_prdata = hidu_pkg::DATA_W'(r_def_thr);
            hidu_pkg::REG_DEF_LEVEL: o_prdata = hidu_pkg::DATA_W'(r_def_lvl);
            hidu_pkg::REG_TIMEOUT:   o_prdata = hidu_pkg::DATA_W'(r_timeout);
            hidu_pkg::REG_BLANKING:  o_prdata = hidu_pkg::DATA_W'(r_blank);
            default:                 o_prdata = '0;
        endcase
    end

    // elapsed time unit
    hidu_elapsed u_elapsed (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (elap_ctl),
        .i_period     (r_period),
        .i_settle     (hidu_pkg::settle_of(r_interval)),
        .i_blank      (r_blank),
        .i_timeout    (r_timeout),
        .o_stat       (elap_stat),
        .o_elapsed_lo (elap_lo)
    );

    // shared divider
    hidu_div #(
        .W (hidu_pkg::DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // sample compares and end-of-beat threshold
    always_comb begin
        below_thr    = r_sample < r_thr;
        above_thr    = r_sample > r_thr;
        sat_interval = elap_stat.over_max ? hidu_pkg::INTERVAL_MAX : elap_lo;
        beat         = elap_stat.gt_blank && above_thr && !r_in_pulse
                       && elap_stat.gt_settle;
        amp          = (r_peak >= r_trough) ? (r_peak - r_trough) : '0;
        mid          = r_trough + (amp >> 1);
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_sample     = r_sample;
        n_interval   = r_interval;
        n_hist       = r_hist;
        n_sum        = r_sum;
        n_thr        = r_thr;
        n_peak       = r_peak;
        n_trough     = r_trough;
        n_in_pulse   = r_in_pulse;
        n_first      = r_first;
        n_second     = r_second;
        n_rate       = r_rate;
        n_fresh      = r_fresh;
        n_avg        = r_avg;
        n_out_valid  = r_out_valid && !i_out_ready;
        elap_ctl     = '0;
        div_start    = 1'b0;
        div_dividend = hidu_pkg::DIV_W'(r_sum);
        div_divisor  = hidu_pkg::DIV_W'(HISTORY_DEPTH);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sample       = i_sample;
                    elap_ctl.start = 1'b1;
                    n_state        = S_ELAP;
                end
            end
            S_ELAP: begin
                if (elap_stat.done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_fresh = 1'b0;
                if (below_thr && elap_stat.gt_settle && r_sample < r_trough) begin
                    n_trough = r_sample;
                end
                if (above_thr && r_sample > r_peak) begin
                    n_peak = r_sample;
                end
                if (beat) begin
                    n_in_pulse     = 1'b1;
                    n_interval     = sat_interval;
                    elap_ctl.clear = 1'b1;
                    if (r_first) begin
                        // first beat only arms the interval measurement
                        n_first  = 1'b0;
                        n_second = 1'b1;
                        n_state  = S_EMIT;
                    end else begin
                        if (r_second) begin
                            // second beat fills the whole history
                            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                                n_hist[i] = sat_interval;
                            end
                            n_sum = SUM_W'(HISTORY_DEPTH) * SUM_W'(sat_interval);
                        end else begin
                            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                                n_hist[i] = r_hist[i+1];
                            end
                            n_hist[HISTORY_DEPTH-1] = sat_interval;
                            n_sum = r_sum - SUM_W'(r_hist[0]) + SUM_W'(sat_interval);
                        end
                        n_second     = 1'b0;
                        n_fresh      = 1'b1;
                        div_start    = 1'b1;
                        div_dividend = hidu_pkg::DIV_W'(n_sum);
                        div_divisor  = hidu_pkg::DIV_W'(HISTORY_DEPTH);
                        n_state      = S_AVG;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_AVG: begin
                if (div_stat.done) begin
                    if (div_quo == '0) begin
                        n_rate  = hidu_pkg::RATE_MAX;
                        n_state = S_FINISH;
                    end else begin
                        n_avg        = div_quo[IW-1:0];
                        div_start    = 1'b1;
                        div_dividend = hidu_pkg::RATE_NUM;
                        div_divisor  = div_quo;
                        n_state      = S_RATE;
                    end
                end
            end
            S_RATE: begin
                if (div_stat.done) begin
                    n_rate  = (div_quo > hidu_pkg::DIV_W'(hidu_pkg::RATE_MAX))
                              ? hidu_pkg::RATE_MAX : div_quo[hidu_pkg::RATE_W-1:0];
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // end of beat: re-center threshold between peak and trough
                if (below_thr && r_in_pulse) begin
                    n_in_pulse = 1'b0;
                    n_thr      = mid;
                    n_peak     = mid;
                    n_trough   = mid;
                end
                // no beat for too long: back to defaults
                if (elap_stat.gt_timeout) begin
                    n_rate         = '0;
                    n_thr          = r_def_thr;
                    n_peak         = r_def_lvl;
                    n_trough       = r_def_lvl;
                    elap_ctl.clear = 1'b1;
                    n_first        = 1'b1;
                    n_second       = 1'b0;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_interval  <= hidu_pkg::RST_INTERVAL;
            r_sum       <= '0;
            r_thr       <= hidu_pkg::RST_THRESHOLD;
            r_peak      <= hidu_pkg::RST_LEVEL;
            r_trough    <= hidu_pkg::RST_LEVEL;
            r_in_pulse  <= 1'b0;
            r_first     <= 1'b1;
            r_second    <= 1'b0;
            r_rate      <= '0;
            r_fresh     <= 1'b0;
            r_avg       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_interval  <= n_interval;
            r_sum       <= n_sum;
            r_thr       <= n_thr;
            r_peak      <= n_peak;
            r_trough    <= n_trough;
            r_in_pulse  <= n_in_pulse;
            r_first     <= n_first;
            r_second    <= n_second;
            r_rate      <= n_rate;
            r_fresh     <= n_fresh;
            r_avg       <= n_avg;
            r_out_valid <= n_out_valid;
            r_hist      <= n_hist;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        if (out_load) begin
            r_o_bpm      <= r_rate;
            r_o_interval <= r_interval;
            r_o_pulse    <= r_in_pulse;
            r_o_fresh    <= r_fresh;
            r_o_thr      <= r_thr;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_beats_per_minute = r_o_bpm;
    assign o_beat_interval_ms = r_o_interval;
    assign o_pulse_active     = r_o_pulse;
    assign o_new_rate         = r_o_fresh;
    assign o_threshold_level  = r_o_thr;

    // checks
    a_beat_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_first && r_second))
        else $error("first and second beat flags both set");

    a_units_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!elap_stat.busy && !div_stat.busy))
        else $error("a serial unit is busy while a new sample may be taken");

    a_emit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not presented after emit");

    a_pulse_rises_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_in_pulse) |-> $past(r_state == S_DECIDE))
        else $error("pulse flag set outside beat decision");

    a_rate_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RATE) |-> (r_avg != '0))
        else $error("rate division started with zero average");

endmodule

@@ rtl/core/hidu_elapsed.sv @@
// hidu_elapsed: digit-serial elapsed-time register with add and compares
// adds the sample period and compares against settle, blanking and timeout
// depends on hidu_pkg
module hidu_elapsed (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hidu_pkg::t_elap_ctl               i_ctl,
    input  logic [hidu_pkg::PERIOD_W-1:0]     i_period,
    input  logic [hidu_pkg::INTERVAL_W-1:0]   i_settle,
    input  logic [hidu_pkg::BLANK_W-1:0]      i_blank,
    input  logic [hidu_pkg::TIMEOUT_W-1:0]    i_timeout,
    output hidu_pkg::t_elap_stat              o_stat,
    output logic [hidu_pkg::INTERVAL_W-1:0]   o_elapsed_lo
);

    localparam int DW = hidu_pkg::DIGIT_W;

    logic [hidu_pkg::ELAP_W-1:0]     r_elapsed;
    logic [hidu_pkg::DCNT_W-1:0]     r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic                            r_carry;
    logic [hidu_pkg::PERIOD_W-1:0]   r_period;
    logic [hidu_pkg::INTERVAL_W-1:0] r_settle_sr;
    logic [hidu_pkg::BLANK_W-1:0]    r_blank_sr;
    logic [hidu_pkg::TIMEOUT_W-1:0]  r_tmo_sr;
    logic                            r_gt_settle;
    logic                            r_gt_blank;
    logic                            r_gt_tmo;
    logic                            r_over;

    logic [DW-1:0] d_add;
    logic [DW:0]   d_sum;
    logic [DW-1:0] d_new;
    logic          last;

    // one digit of elapsed + period per cycle, lsb first
    always_comb begin
        d_add = (r_cnt == '0) ? DW'(r_period) : '0;
        d_sum = {1'b0, r_elapsed[DW-1:0]} + {1'b0, d_add} + (DW+1)'(r_carry);
        d_new = d_sum[DW-1:0];
        last  = (r_cnt == hidu_pkg::DCNT_W'(hidu_pkg::NDIG - 1));
    end

    // digit loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_cnt     <= '0;
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_carry   <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (r_busy) begin
                r_elapsed <= {d_new, r_elapsed[hidu_pkg::ELAP_W-1:DW]};
                r_carry   <= d_sum[DW];
                r_cnt     <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end else if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_carry <= 1'b0;
            end else if (i_ctl.clear) begin
                r_elapsed <= '0;
            end
        end
    end

    // operand shift lines and lsb-first compare flags
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_ctl.start) begin
            r_period    <= i_period;
            r_settle_sr <= i_settle;
            r_blank_sr  <= i_blank;
            r_tmo_sr    <= i_timeout;
            r_gt_settle <= 1'b0;
            r_gt_blank  <= 1'b0;
            r_gt_tmo    <= 1'b0;
            r_over      <= 1'b0;
        end else if (r_busy) begin
            r_settle_sr <= r_settle_sr >> DW;
            r_blank_sr  <= r_blank_sr >> DW;
            r_tmo_sr    <= r_tmo_sr >> DW;
            r_gt_settle <= (d_new > r_settle_sr[DW-1:0])
                           || ((d_new == r_settle_sr[DW-1:0]) && r_gt_settle);
            r_gt_blank  <= (d_new > r_blank_sr[DW-1:0])
                           || ((d_new == r_blank_sr[DW-1:0]) && r_gt_blank);
            r_gt_tmo    <= (d_new > r_tmo_sr[DW-1:0])
                           || ((d_new == r_tmo_sr[DW-1:0]) && r_gt_tmo);
            if (r_cnt >= hidu_pkg::DCNT_W'(hidu_pkg::LO_DIGITS) && d_new != '0) begin
                r_over <= 1'b1;
            end
        end
    end

    assign o_stat.busy       = r_busy;
    assign o_stat.done       = r_done;
    assign o_stat.gt_settle  = r_gt_settle;
    assign o_stat.gt_blank   = r_gt_blank;
    assign o_stat.gt_timeout = r_gt_tmo;
    assign o_stat.over_max   = r_over;
    assign o_elapsed_lo      = r_elapsed[hidu_pkg::INTERVAL_W-1:0];

endmodule

@@ rtl/core/hidu_div.sv @@
// hidu_div: bit-serial restoring divider, one quotient bit per cycle
// used for the history average and for the rate division
// depends on hidu_pkg
module hidu_div #(
    parameter int W = hidu_pkg::DIV_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [W-1:0]        i_dividend,
    input  logic [W-1:0]        i_divisor,
    output hidu_pkg::t_div_stat o_stat,
    output logic [W-1:0]        o_quotient
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0] shifted;
    logic [W:0] diff;
    logic       qbit;
    logic       last;

    // trial subtract of the shifted remainder
    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        diff    = shifted - {1'b0, r_div};
        qbit    = ~diff[W];
        last    = (r_cnt == CNT_W'(W - 1));
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    // datapath: dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[W-1:0] : shifted[W-1:0];
            r_quo <= {r_quo[W-2:0], qbit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule
